/* src/pms_pkg.sv */
package pms_pkg;

	localparam int KIND_W    = 2;
	localparam int DATA_W    = 64;
	localparam int GROUP_W   = 7;
	localparam int PERIOD_W  = 13;
	localparam int INDEX_W   = 12;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int FILL_W    = 13;
	localparam int MUL_W     = 2 * PERIOD_W;
	localparam int PROD_W    = 21;

	typedef enum logic [KIND_W-1:0] {
		KIND_PLACE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_BAD_READ = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUP_COUNT = 3'd0,
		CFG_PERIODS     = 3'd1,
		CFG_TIME_MODE   = 3'd2,
		CFG_TRANSPOSE   = 3'd3,
		CFG_MISSING     = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'd0,
		ST_IDLE  = 3'd1,
		ST_CHECK = 3'd2,
		ST_ADDR  = 3'd3,
		ST_EXEC  = 3'd4
	} state_t;

endpackage

/* src/pms_if.sv */
interface pms_req_if;
	logic                            valid;
	logic                            ready;
	logic [pms_pkg::KIND_W-1:0]      kind;
	logic [pms_pkg::DATA_W-1:0]      value;
	logic [pms_pkg::GROUP_W-1:0]     group_id;
	logic [pms_pkg::PERIOD_W-1:0]    period_id;
	logic [pms_pkg::INDEX_W-1:0]     cell_index;

	modport source (output valid, kind, value, group_id, period_id, cell_index, input ready);
	modport sink (input valid, kind, value, group_id, period_id, cell_index, output ready);
endinterface

interface pms_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pms_pkg::DATA_W-1:0]      read_data;
	logic [pms_pkg::INDEX_W-1:0]     cell_address;
	logic [pms_pkg::STATUS_W-1:0]    status;

	modport source (output valid, read_data, cell_address, status, input ready);
	modport sink (input valid, read_data, cell_address, status, output ready);
endinterface

interface pms_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pms_pkg::CFG_IDX_W-1:0]   index;
	logic [pms_pkg::DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/pms_ram.sv */
module pms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/panel_to_matrix_scatter.sv */
// Scatters panel elements into a column-major group-by-period matrix held in on-chip RAM.
// A place request writes its value at the cell for its group and period (period from a
// per-group fill counter in balanced mode, from period_id in time mode); a read request
// returns the cell or missing_word if it was not written since the last clear; a clear
// request returns zeros and resets fill counters and written marks. Every request gives
// exactly one response. One request is in flight at a time and passes in order through
// RAM read, range check, address multiply-add, and write and response; a new request is
// taken only once the previous response has been registered. After reset and after each
// clear the block sweeps every address of both RAMs with req.ready low; configuration
// writes are taken at any time but should only be issued while the block is idle.
module panel_to_matrix_scatter #(
	parameter int MAX_GROUPS = 64,
	parameter int MAX_CELLS  = 4096,
	parameter int DATA_WIDTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	pms_req_if.sink      req,
	pms_rsp_if.source    rsp,
	pms_cfg_if.sink      cfg
);
	import pms_pkg::*;

	localparam int AW          = $clog2(MAX_CELLS);
	localparam int CELL_DEPTH  = 1 << AW;
	localparam int GW          = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GROUP_DEPTH = 1 << GW;
	localparam int SWEEP_N     = (CELL_DEPTH > GROUP_DEPTH) ? CELL_DEPTH : GROUP_DEPTH;
	localparam int SW          = $clog2(SWEEP_N);
	localparam int CIW         = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int GIW         = (GW > GROUP_W) ? GW : GROUP_W;
	localparam logic [SW-1:0] SWEEP_LAST = SW'(SWEEP_N - 1);

	// configuration
	logic [GROUP_W-1:0]    gc_q;
	logic [PERIOD_W-1:0]   ppg_q;
	logic                  tmode_q;
	logic                  transp_q;
	logic [DATA_WIDTH-1:0] missing_q;

	// request held while in flight
	kind_t                 kind_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [GROUP_W-1:0]    gid_q;
	logic [PERIOD_W-1:0]   pid_q;
	logic [INDEX_W-1:0]    cidx_q;

	state_t                st_q, st_d;
	logic [SW-1:0]         sweep_q;

	logic [FILL_W-1:0]     period_s1;
	status_t               stat_s1;
	logic [PERIOD_W-1:0]   mul_a_s1, mul_b_s1, add_s1;
	logic [PROD_W-1:0]     prod_s2;

	logic                  rsp_valid_q;
	logic [DATA_W-1:0]     rsp_data_q;
	logic [INDEX_W-1:0]    rsp_addr_q;
	status_t               rsp_stat_q;

	logic                  req_acc;
	logic                  slot_free;
	logic                  emit;
	logic                  cell_we, fill_we;
	logic [AW-1:0]         cell_waddr, cell_raddr;
	logic [DATA_WIDTH:0]   cell_wdata, cell_rdata;
	logic [GW-1:0]         fill_waddr, fill_raddr, gidx;
	logic [FILL_W-1:0]     fill_wdata, fill_rdata;

	logic [GROUP_W-1:0]    req_gidm1, gidm1;
	logic [GIW-1:0]        req_gidx_ext, gidx_ext;
	logic [CIW-1:0]        cidx_ext;
	logic [FILL_W-1:0]     period_c;
	status_t               stat_c;
	logic [PERIOD_W-1:0]   mul_a_c, mul_b_c, add_c;
	logic [MUL_W-1:0]      prod_full;

	logic                  exec_write, exec_fill;
	logic [DATA_W-1:0]     res_data;
	logic [INDEX_W-1:0]    res_addr;
	status_t               res_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q      <= GROUP_W'(1);
			ppg_q     <= PERIOD_W'(1);
			tmode_q   <= 1'b0;
			transp_q  <= 1'b0;
			missing_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GROUP_COUNT: gc_q      <= cfg.data[GROUP_W-1:0];
				CFG_PERIODS:     ppg_q     <= cfg.data[PERIOD_W-1:0];
				CFG_TIME_MODE:   tmode_q   <= cfg.data[0];
				CFG_TRANSPOSE:   transp_q  <= cfg.data[0];
				CFG_MISSING:     missing_q <= cfg.data[DATA_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign slot_free    = !rsp_valid_q || rsp.ready;
	assign req_gidm1    = req.group_id - GROUP_W'(1);
	assign req_gidx_ext = GIW'(req_gidm1);
	assign gidm1        = gid_q - GROUP_W'(1);
	assign gidx_ext     = GIW'(gidm1);
	assign gidx         = gidx_ext[GW-1:0];
	assign cidx_ext     = CIW'(req.cell_index);
	assign cell_raddr   = cidx_ext[AW-1:0];
	assign fill_raddr   = req_gidx_ext[GW-1:0];

	pms_ram #(
		.WIDTH (DATA_WIDTH + 1),
		.DEPTH (CELL_DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (req_acc),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	pms_ram #(
		.WIDTH (FILL_W),
		.DEPTH (GROUP_DEPTH)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (req_acc),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	// range checks and multiply operands
	always_comb begin
		period_c = '0;
		stat_c   = STAT_OK;
		mul_a_c  = PERIOD_W'(gc_q);
		mul_b_c  = ppg_q;
		add_c    = '0;
		if (kind_q == KIND_PLACE) begin
			if (gid_q == '0 || gid_q > gc_q || 32'(gid_q) > MAX_GROUPS) begin
				stat_c = STAT_RANGE;
			end else if (!tmode_q) begin
				period_c = fill_rdata;
				if (fill_rdata >= ppg_q) begin
					stat_c = STAT_FULL;
				end
			end else if (pid_q == '0 || pid_q > ppg_q) begin
				stat_c = STAT_RANGE;
			end else begin
				period_c = pid_q - PERIOD_W'(1);
			end
			if (transp_q) begin
				mul_a_c = PERIOD_W'(gidm1);
				mul_b_c = ppg_q;
				add_c   = period_c;
			end else begin
				mul_a_c = period_c;
				mul_b_c = PERIOD_W'(gc_q);
				add_c   = PERIOD_W'(gidm1);
			end
		end
	end

	assign prod_full = MUL_W'(mul_a_s1) * MUL_W'(mul_b_s1) + MUL_W'(add_s1);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q  <= kind_t'(req.kind);
			value_q <= req.value[DATA_WIDTH-1:0];
			gid_q   <= req.group_id;
			pid_q   <= req.period_id;
			cidx_q  <= req.cell_index;
		end
		if (st_q == ST_CHECK) begin
			period_s1 <= period_c;
			stat_s1   <= stat_c;
			mul_a_s1  <= mul_a_c;
			mul_b_s1  <= mul_b_c;
			add_s1    <= add_c;
		end
		if (st_q == ST_ADDR) begin
			prod_s2 <= prod_full[PROD_W-1:0];
		end
	end

	// result of the request in the execute state
	always_comb begin
		res_data   = '0;
		res_addr   = '0;
		res_stat   = STAT_OK;
		exec_write = 1'b0;
		exec_fill  = 1'b0;
		case (kind_q)
			KIND_PLACE: begin
				if (stat_s1 != STAT_OK) begin
					res_stat = stat_s1;
				end else begin
					res_addr = prod_s2[INDEX_W-1:0];
					if (32'(prod_s2) >= MAX_CELLS) begin
						res_stat = STAT_RANGE;
					end else begin
						exec_write = 1'b1;
						exec_fill  = !tmode_q;
					end
				end
			end
			KIND_READ: begin
				res_addr = cidx_q;
				if (PROD_W'(cidx_q) >= prod_s2 || 32'(cidx_q) >= MAX_CELLS) begin
					res_stat = STAT_BAD_READ;
				end else if (cell_rdata[DATA_WIDTH]) begin
					res_data = DATA_W'(cell_rdata[DATA_WIDTH-1:0]);
				end else begin
					res_data = DATA_W'(missing_q);
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_SWEEP: if (sweep_q == SWEEP_LAST) st_d = ST_IDLE;
			ST_IDLE:  if (req.valid) st_d = ST_CHECK;
			ST_CHECK: st_d = ST_ADDR;
			ST_ADDR:  st_d = ST_EXEC;
			ST_EXEC: begin
				if (slot_free) begin
					st_d = (kind_q == KIND_CLEAR) ? ST_SWEEP : ST_IDLE;
				end
			end
			default:  st_d = ST_SWEEP;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready  = 1'b0;
		emit       = 1'b0;
		cell_we    = 1'b0;
		fill_we    = 1'b0;
		cell_waddr = prod_s2[AW-1:0];
		cell_wdata = {1'b1, value_q};
		fill_waddr = gidx;
		fill_wdata = period_s1 + FILL_W'(1);
		case (st_q)
			ST_SWEEP: begin
				cell_we    = 1'b1;
				fill_we    = 1'b1;
				cell_waddr = sweep_q[AW-1:0];
				cell_wdata = '0;
				fill_waddr = sweep_q[GW-1:0];
				fill_wdata = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_EXEC: begin
				emit    = slot_free;
				cell_we = slot_free && exec_write;
				fill_we = slot_free && exec_fill;
			end
			default: begin
			end
		endcase
	end

	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_SWEEP;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_SWEEP) begin
				sweep_q <= sweep_q + SW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_data_q <= res_data;
			rsp_addr_q <= res_addr;
			rsp_stat_q <= res_stat;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_data    = rsp_data_q;
	assign rsp.cell_address = rsp_addr_q;
	assign rsp.status       = rsp_stat_q;
endmodule

/* src/pms_checker.sv */
module pms_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [pms_pkg::DATA_W-1:0]     rsp_read_data,
	input logic [pms_pkg::STATUS_W-1:0]   rsp_status
);
	import pms_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	// requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_read_data == '0)
		else $error("error response with nonzero data");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a request");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");
endmodule

bind panel_to_matrix_scatter pms_checker u_pms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_status    (rsp.status)
);

/* sim/tb_panel_to_matrix_scatter.sv */
module tb_panel_to_matrix_scatter;

	import pms_pkg::*;

	localparam int MAX_GROUPS = 64;
	localparam int MAX_CELLS = 4096;
	localparam int RANDOM_PER_SETTING = 134;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [DATA_W-1:0]   value;
		logic [GROUP_W-1:0]  group_id;
		logic [PERIOD_W-1:0] period_id;
		logic [INDEX_W-1:0]  cell_index;
	} cell_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic [INDEX_W-1:0] cell_address;
		status_t            status;
	} cell_rsp_t;

	typedef struct packed {
		logic [GROUP_W-1:0]  groups;
		logic [PERIOD_W-1:0] periods;
		logic                time_mode;
		logic                transpose;
		logic [DATA_W-1:0]   missing;
	} panel_cfg_t;

	typedef struct packed {
		logic       reshape;
		cell_req_t  req;
		logic       fixed;
		cell_rsp_t  want;
		panel_cfg_t cfg;
	} plan_row_t;

	logic clk;
	logic arst_n;

	pms_req_if req_bus ();
	pms_rsp_if rsp_bus ();
	pms_cfg_if cfg_bus ();

	panel_to_matrix_scatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	int unsigned panel_groups = 1;
	int unsigned panel_periods = 1;
	logic panel_time = 1'b0;
	logic panel_trans = 1'b0;
	logic [DATA_W-1:0] panel_missing = '0;
	int unsigned group_fill [MAX_GROUPS];
	logic [DATA_W-1:0] cell_word [MAX_CELLS];
	logic cell_seen [MAX_CELLS];

	cell_rsp_t expected_cells [$];
	plan_row_t plan [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle = 0;
	int receiver_stall = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic cell_rsp_t scatter_cell(input cell_req_t r);
		cell_rsp_t o;
		int unsigned period;
		int unsigned gidx;
		int unsigned a;
		o.read_data = '0;
		o.cell_address = '0;
		o.status = STAT_OK;
		period = 0;
		gidx = 0;
		if (r.kind == KIND_PLACE) begin
			if (r.group_id == 0 || r.group_id > panel_groups || r.group_id > MAX_GROUPS) begin
				o.status = STAT_RANGE;
			end else begin
				gidx = int'(r.group_id) - 1;
				if (!panel_time) begin
					period = group_fill[gidx];
					if (period >= panel_periods)
						o.status = STAT_FULL;
				end else if (r.period_id == 0 || r.period_id > panel_periods) begin
					o.status = STAT_RANGE;
				end else begin
					period = int'(r.period_id) - 1;
				end
			end
			if (o.status == STAT_OK) begin
				a = panel_trans ? gidx * panel_periods + period : period * panel_groups + gidx;
				o.cell_address = a[INDEX_W-1:0];
				if (a >= MAX_CELLS) begin
					o.status = STAT_RANGE;
				end else begin
					cell_word[a] = r.value;
					cell_seen[a] = 1'b1;
					if (!panel_time)
						group_fill[gidx] = period + 1;
				end
			end
		end else if (r.kind == KIND_READ) begin
			o.cell_address = r.cell_index;
			if (r.cell_index >= panel_groups * panel_periods || r.cell_index >= MAX_CELLS)
				o.status = STAT_BAD_READ;
			else
				o.read_data = cell_seen[r.cell_index] ? cell_word[r.cell_index] : panel_missing;
		end else if (r.kind == KIND_CLEAR) begin
			foreach (group_fill[i])
				group_fill[i] = 0;
			foreach (cell_seen[i])
				cell_seen[i] = 1'b0;
		end
		return o;
	endfunction

	function automatic plan_row_t ask(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
			input logic [GROUP_W-1:0] gid, input logic [PERIOD_W-1:0] pid,
			input logic [INDEX_W-1:0] cidx);
		plan_row_t row;
		row = '0;
		row.req.kind = kind;
		row.req.value = value;
		row.req.group_id = gid;
		row.req.period_id = pid;
		row.req.cell_index = cidx;
		return row;
	endfunction

	function automatic plan_row_t ask_want(input logic [KIND_W-1:0] kind,
			input logic [DATA_W-1:0] value, input logic [GROUP_W-1:0] gid,
			input logic [PERIOD_W-1:0] pid, input logic [INDEX_W-1:0] cidx,
			input logic [DATA_W-1:0] rd, input logic [INDEX_W-1:0] ad, input status_t st);
		plan_row_t row;
		row = ask(kind, value, gid, pid, cidx);
		row.fixed = 1'b1;
		row.want.read_data = rd;
		row.want.cell_address = ad;
		row.want.status = st;
		return row;
	endfunction

	function automatic plan_row_t reshape(input logic [GROUP_W-1:0] gc,
			input logic [PERIOD_W-1:0] ppg, input logic tm, input logic tr,
			input logic [DATA_W-1:0] miss);
		plan_row_t row;
		row = '0;
		row.reshape = 1'b1;
		row.cfg.groups = gc;
		row.cfg.periods = ppg;
		row.cfg.time_mode = tm;
		row.cfg.transpose = tr;
		row.cfg.missing = miss;
		return row;
	endfunction

	task automatic program_panel(input panel_cfg_t c);
		cfg_idx_t idx [5];
		logic [DATA_W-1:0] word [5];
		idx = '{CFG_GROUP_COUNT, CFG_PERIODS, CFG_TIME_MODE, CFG_TRANSPOSE, CFG_MISSING};
		word = '{DATA_W'(c.groups), DATA_W'(c.periods), DATA_W'(c.time_mode),
			DATA_W'(c.transpose), c.missing};
		req_bus.valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[i];
			cfg_bus.data <= word[i];
			do
				@(posedge clk);
			while (cfg_bus.ready !== 1'b1);
			case (idx[i])
				CFG_GROUP_COUNT: panel_groups = 32'(word[i][GROUP_W-1:0]);
				CFG_PERIODS:     panel_periods = 32'(word[i][PERIOD_W-1:0]);
				CFG_TIME_MODE:   panel_time = word[i][0];
				CFG_TRANSPOSE:   panel_trans = word[i][0];
				CFG_MISSING:     panel_missing = word[i];
				default: ;
			endcase
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_cell(input cell_req_t r, input logic fixed, input cell_rsp_t want);
		cell_rsp_t predicted;
		while ($urandom_range(99) < sender_idle) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.kind <= r.kind;
		req_bus.value <= r.value;
		req_bus.group_id <= r.group_id;
		req_bus.period_id <= r.period_id;
		req_bus.cell_index <= r.cell_index;
		do
			@(posedge clk);
		while (req_bus.ready !== 1'b1);
		predicted = scatter_cell(r);
		expected_cells.push_back(fixed ? want : predicted);
	endtask

	always @(posedge clk)
		rsp_bus.ready <= ($urandom_range(99) >= receiver_stall);

	always @(posedge clk) begin
		cell_rsp_t want;
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (expected_cells.size() == 0) begin
				$error("response with no request waiting: read_data %h cell_address %0d status %0d",
					rsp_bus.read_data, rsp_bus.cell_address, rsp_bus.status);
				mismatch_count++;
			end else begin
				want = expected_cells.pop_front();
				if (rsp_bus.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, rsp_bus.read_data);
					mismatch_count++;
				end
				if (rsp_bus.cell_address !== want.cell_address) begin
					$error("cell_address: expected %0d, got %0d", want.cell_address,
						rsp_bus.cell_address);
					mismatch_count++;
				end
				if (rsp_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_panel_to_matrix_scatter failed");
			$finish;
		end
	end

	initial begin
		panel_cfg_t pick;
		cell_req_t r;
		int unsigned cells;
		int unsigned pid_hi;
		int unsigned roll;
		foreach (group_fill[i])
			group_fill[i] = 0;
		foreach (cell_seen[i])
			cell_seen[i] = 1'b0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.kind <= KIND_PLACE;
		req_bus.value <= '0;
		req_bus.group_id <= '0;
		req_bus.period_id <= '0;
		req_bus.cell_index <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_GROUP_COUNT;
		cfg_bus.data <= '0;

		plan = '{
			reshape(7'd3, 13'd2, 1'b0, 1'b0, ALL_ONES),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd0, ALL_ONES, 12'd0, STAT_OK),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd4095, '0, 12'd4095, STAT_BAD_READ),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd6, '0, 12'd6, STAT_BAD_READ),
			ask_want(KIND_PLACE, ALL_ONES, 7'd0, 13'd1, 12'd0, '0, 12'd0, STAT_RANGE),
			ask_want(KIND_PLACE, ALL_ONES, 7'd4, 13'd1, 12'd0, '0, 12'd0, STAT_RANGE),
			ask_want(KIND_PLACE, ALL_ONES, 7'd127, 13'd1, 12'd0, '0, 12'd0, STAT_RANGE),
			ask_want(KIND_PLACE, ALL_ONES, 7'd1, 13'd0, 12'd0, '0, 12'd0, STAT_OK),
			ask_want(KIND_PLACE, '0, 7'd1, 13'd0, 12'd0, '0, 12'd3, STAT_OK),
			ask_want(KIND_PLACE, 64'h1, 7'd1, 13'd0, 12'd0, '0, 12'd0, STAT_FULL),
			ask(KIND_PLACE, 64'h0123_4567_89ab_cdef, 7'd3, 13'd8191, 12'd4095),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd0, ALL_ONES, 12'd0, STAT_OK),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd3, '0, 12'd3, STAT_OK),
			ask(KIND_READ, '0, 7'd0, 13'd0, 12'd2),
			ask_want(KIND_UNUSED, ALL_ONES, 7'd127, 13'd8191, 12'd4095, '0, 12'd0, STAT_OK),
			ask_want(KIND_CLEAR, ALL_ONES, 7'd127, 13'd8191, 12'd4095, '0, 12'd0, STAT_OK),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd0, ALL_ONES, 12'd0, STAT_OK),
			reshape(7'd3, 13'd2, 1'b1, 1'b1, '0),
			ask_want(KIND_PLACE, ALL_ONES, 7'd2, 13'd0, 12'd0, '0, 12'd0, STAT_RANGE),
			ask_want(KIND_PLACE, ALL_ONES, 7'd2, 13'd8191, 12'd0, '0, 12'd0, STAT_RANGE),
			ask(KIND_PLACE, 64'hfedc_ba98_7654_3210, 7'd2, 13'd2, 12'd0),
			ask(KIND_READ, '0, 7'd0, 13'd0, 12'd3),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd1, '0, 12'd1, STAT_OK),
			reshape(7'd64, 13'd4096, 1'b0, 1'b1, 64'h5a5a_a5a5_0ff0_f00f),
			ask_want(KIND_PLACE, ALL_ONES, 7'd2, 13'd0, 12'd0, '0, 12'd0, STAT_RANGE),
			ask_want(KIND_PLACE, ALL_ONES, 7'd64, 13'd0, 12'd0, '0, 12'd0, STAT_RANGE),
			ask(KIND_PLACE, 64'h8000_0000_0000_0001, 7'd1, 13'd0, 12'd0),
			ask_want(KIND_READ, '0, 7'd0, 13'd0, 12'd4095, 64'h5a5a_a5a5_0ff0_f00f, 12'd4095,
				STAT_OK)
		};

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		sender_idle = 14;
		receiver_stall = 77;
		foreach (plan[i]) begin
			if (plan[i].reshape)
				program_panel(plan[i].cfg);
			else
				send_cell(plan[i].req, plan[i].fixed, plan[i].want);
		end

		for (int mode = 0; mode < 3; mode++) begin
			sender_idle = (mode == 0) ? 14 : (mode == 1) ? 77 : 0;
			receiver_stall = (mode == 0) ? 77 : (mode == 1) ? 14 : 0;
			for (int j = 0; j < 3; j++) begin
				case (mode * 3 + j)
					0: pick = '{groups: 7'd1, periods: 13'd1, time_mode: 1'b0, transpose: 1'b0,
						missing: ALL_ONES};
					4: pick = '{groups: 7'd64, periods: 13'd4096, time_mode: 1'b1, transpose: 1'b0,
						missing: '0};
					8: pick = '{groups: 7'd64, periods: 13'd64, time_mode: 1'b0, transpose: 1'b1,
						missing: {$urandom, $urandom}};
					default: pick = '{groups: GROUP_W'($urandom_range(8, 1)),
						periods: PERIOD_W'($urandom_range(16, 1)),
						time_mode: 1'($urandom_range(1)), transpose: 1'($urandom_range(1)),
						missing: {$urandom, $urandom}};
				endcase
				program_panel(pick);
				cells = int'(pick.groups) * int'(pick.periods);
				if (cells > MAX_CELLS)
					cells = MAX_CELLS;
				repeat (RANDOM_PER_SETTING) begin
					pid_hi = (pick.periods > 64 && $urandom_range(1) == 1) ? 64 : pick.periods;
					roll = $urandom_range(99);
					r.value = {$urandom, $urandom};
					r.group_id = GROUP_W'($urandom);
					r.period_id = PERIOD_W'($urandom);
					r.cell_index = INDEX_W'($urandom);
					if (roll < 2) begin
						r.kind = KIND_CLEAR;
					end else if (roll < 4) begin
						r.kind = KIND_UNUSED;
					end else if (roll < 60) begin
						r.kind = KIND_PLACE;
						if ($urandom_range(9) != 0) begin
							r.group_id = GROUP_W'($urandom_range(pick.groups, 1));
							r.period_id = PERIOD_W'($urandom_range(pid_hi, 1));
						end
					end else begin
						r.kind = KIND_READ;
						if ($urandom_range(9) != 0)
							r.cell_index = INDEX_W'($urandom_range(cells - 1, 0));
					end
					send_cell(r, 1'b0, '0);
				end
			end
		end

		// drain outstanding responses, then watch for strays
		req_bus.valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (16)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("tb_panel_to_matrix_scatter passed");
		else
			$display("tb_panel_to_matrix_scatter failed");
		$finish;
	end

endmodule
